>>> src/usart_pkg.sv
// ----------------------------------------------------------------------------
// usart_pkg
// Shared types, codes and helpers for the byte-level USART core.
// ----------------------------------------------------------------------------
package usart_pkg;

  parameter int unsigned RX_FIFO_DEPTH = 16;

  typedef enum logic [2:0] {
    ACT_READ      = 3'd0,
    ACT_WRITE     = 3'd1,
    ACT_TX_TICK   = 3'd2,
    ACT_RX_TICK   = 3'd3,
    ACT_LINE_BYTE = 3'd4
  } action_e;

  // register select codes
  localparam logic REG_DATA = 1'b0;
  localparam logic REG_CTRL = 1'b1;

  // command word bits
  localparam int unsigned CMD_TXEN_BIT = 0;
  localparam int unsigned CMD_RXE_BIT  = 2;
  localparam int unsigned CMD_ER_BIT   = 4;
  localparam int unsigned CMD_IR_BIT   = 6;

  // mode word fields
  localparam int unsigned MODE_PARITY_BIT = 4;
  localparam logic [1:0]  DIV_X16  = 2'b10;
  localparam logic [1:0]  DIV_X64  = 2'b11;
  localparam logic [1:0]  STOP_TWO = 2'b11;

  // status bit positions
  localparam int unsigned ST_TXRDY   = 0;
  localparam int unsigned ST_RXRDY   = 1;
  localparam int unsigned ST_TXEMPTY = 2;
  localparam int unsigned ST_OVERRUN = 4;
  localparam int unsigned ST_DSR     = 7;

  localparam int unsigned EDGE_W = 10;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] status_bits;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       queue_dropped;
  } rsp_t;

  // Character length in ticks: start + data + parity + stop, times divisor.
  function automatic logic [EDGE_W-1:0] char_ticks(input logic [7:0] mode);
    logic [3:0] bits;
    bits = 4'd6 + {2'b00, mode[3:2]} + {3'b000, mode[MODE_PARITY_BIT]}
         + ((mode[7:6] == STOP_TWO) ? 4'd2 : 4'd1);
    unique case (mode[1:0])
      DIV_X16: char_ticks = {2'b00, bits, 4'b0000};
      DIV_X64: char_ticks = {bits, 6'b000000};
      default: char_ticks = {6'b000000, bits};
    endcase
  endfunction

  function automatic logic [7:0] status_word(input logic txh_valid, input logic tx_busy,
                                             input logic rx_ready, input logic overrun);
    logic [7:0] s;
    s = 8'h00;
    s[ST_DSR]     = 1'b1;
    s[ST_TXRDY]   = ~txh_valid;
    s[ST_TXEMPTY] = ~txh_valid & ~tx_busy;
    s[ST_RXRDY]   = rx_ready;
    s[ST_OVERRUN] = overrun;
    status_word = s;
  endfunction

endpackage

>>> src/usart_req_if.sv
// ----------------------------------------------------------------------------
// usart_req_if
// Request channel: bus accesses, baud ticks and line bytes.
// ----------------------------------------------------------------------------
interface usart_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic       reg_select;
  logic [7:0] write_data;
  logic [7:0] line_byte;

  modport source (output valid, action, reg_select, write_data, line_byte, input ready);
  modport sink   (input valid, action, reg_select, write_data, line_byte, output ready);
endinterface

>>> src/usart_rsp_if.sv
// ----------------------------------------------------------------------------
// usart_rsp_if
// Result channel: read data, status and transmit/drop events.
// ----------------------------------------------------------------------------
interface usart_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [7:0] status_bits;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       queue_dropped;

  modport source (output valid, read_data, status_bits, tx_valid, tx_byte, queue_dropped,
                  input ready);
  modport sink   (input valid, read_data, status_bits, tx_valid, tx_byte, queue_dropped,
                  output ready);
endinterface

>>> src/usart_fifo_ram.sv
// ----------------------------------------------------------------------------
// usart_fifo_ram
// Receive FIFO storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module usart_fifo_ram #(
  parameter int unsigned DEPTH = usart_pkg::RX_FIFO_DEPTH,
  parameter int unsigned PTR_W = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [PTR_W-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [PTR_W-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/usart_out_skid.sv
// ----------------------------------------------------------------------------
// usart_out_skid
// Two-entry output register with skid stage on the result channel.
// ----------------------------------------------------------------------------
module usart_out_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  usart_pkg::rsp_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output usart_pkg::rsp_t   out_data_o
);

  logic            main_v_q, main_v_d, skid_v_q, skid_v_d;
  usart_pkg::rsp_t main_q, main_d, skid_q, skid_d;
  logic            push, pop;

  assign in_ready_o  = ~skid_v_q;
  assign push        = in_valid_i & in_ready_o;
  assign pop         = main_v_q & out_ready_i;
  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (pop || !main_v_q) begin
      if (skid_v_q) begin
        // advance the parked result into the output slot
        main_d   = skid_q;
        main_v_d = 1'b1;
        skid_v_d = 1'b0;
      end else begin
        main_d   = in_data_i;
        main_v_d = push;
      end
    end else if (push) begin
      skid_d   = in_data_i;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

>>> src/usart_byte_level_model_core.sv
// ----------------------------------------------------------------------------
// usart_byte_level_model_core
// Byte-level 8251-style USART with receive FIFO and optional loopback.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one request per handshake: a bus read, a bus write, a
//   transmit tick, a receive tick or a byte arriving from the line. Every
//   request yields exactly one result on out_o: read data, status after the
//   request, a finished transmit character and a FIFO drop flag.
//   Throughput is one request per clock while in_i.ready is high. Each
//   request is worked off in the cycle it is accepted; its result is
//   registered in the output slot, or in the skid slot if that is held.
//   Line bytes and loopback characters land in a single-port-write FIFO
//   memory with a registered read; a receive tick that starts a character
//   issues the read, and the byte is consumed no earlier than seven ticks
//   later, so no forwarding path is needed.
//   cfg_we_i / cfg_wdata_i write the loopback enable; write it only while
//   the block is idle. An internal-reset command leaves it unchanged.
//   Reset (rst_ni low) clears all control state and empties the FIFO at
//   once; no clearing pass runs, stale FIFO entries are never read.
//   When the receiver stalls, a skid stage parks one more result; in_i.ready
//   drops only when both output slots are full.
// ----------------------------------------------------------------------------
module usart_byte_level_model_core #(
  parameter int unsigned RX_FIFO_DEPTH = usart_pkg::RX_FIFO_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  usart_req_if.sink      in_i,
  usart_rsp_if.source    out_o
);

  localparam int unsigned PTR_W  = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(RX_FIFO_DEPTH + 1);
  localparam int unsigned EDGE_W = usart_pkg::EDGE_W;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RX_FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RX_FIFO_DEPTH);

  // state
  logic              loopback_q;
  logic              awaiting_q, awaiting_d;
  logic [7:0]        mode_q, mode_d;
  logic [7:0]        cmd_q, cmd_d;
  logic [7:0]        txh_byte_q, txh_byte_d;
  logic              txh_v_q, txh_v_d;
  logic              tx_busy_q, tx_busy_d;
  logic [7:0]        tx_shift_q, tx_shift_d;
  logic [EDGE_W-1:0] tx_edges_q, tx_edges_d;
  logic [7:0]        rxd_byte_q, rxd_byte_d;
  logic              rxd_rdy_q, rxd_rdy_d;
  logic              ovr_q, ovr_d;
  logic              rx_busy_q, rx_busy_d;
  logic [EDGE_W-1:0] rx_edges_q, rx_edges_d;
  logic [PTR_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;

  logic              acc;
  logic              push_req;
  logic [7:0]        push_byte;
  logic              fifo_we, fifo_re;
  logic [7:0]        rx_shift;
  logic              go;
  usart_pkg::rsp_t   rsp;
  usart_pkg::rsp_t   out_data;
  logic              skid_ready;

  assign acc        = in_i.valid & skid_ready;
  assign in_i.ready = skid_ready;

  always_comb begin
    awaiting_d = awaiting_q;
    mode_d     = mode_q;
    cmd_d      = cmd_q;
    txh_byte_d = txh_byte_q;
    txh_v_d    = txh_v_q;
    tx_busy_d  = tx_busy_q;
    tx_shift_d = tx_shift_q;
    tx_edges_d = tx_edges_q;
    rxd_byte_d = rxd_byte_q;
    rxd_rdy_d  = rxd_rdy_q;
    ovr_d      = ovr_q;
    rx_busy_d  = rx_busy_q;
    rx_edges_d = rx_edges_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    push_req   = 1'b0;
    push_byte  = in_i.line_byte;
    fifo_we    = 1'b0;
    fifo_re    = 1'b0;
    go         = 1'b1;
    rsp        = '0;

    unique case (in_i.action)
      usart_pkg::ACT_READ: begin
        if (in_i.reg_select == usart_pkg::REG_CTRL) begin
          rsp.read_data = usart_pkg::status_word(txh_v_q, tx_busy_q, rxd_rdy_q, ovr_q);
        end else begin
          rxd_rdy_d     = 1'b0;
          rsp.read_data = rxd_byte_q;
        end
      end
      usart_pkg::ACT_WRITE: begin
        if (in_i.reg_select == usart_pkg::REG_DATA) begin
          // overwrite a full holding register
          txh_byte_d = in_i.write_data;
          txh_v_d    = 1'b1;
        end else if (awaiting_q) begin
          mode_d     = in_i.write_data;
          awaiting_d = 1'b0;
        end else begin
          cmd_d = in_i.write_data;
          if (in_i.write_data[usart_pkg::CMD_ER_BIT]) begin
            ovr_d = 1'b0;
          end
          if (in_i.write_data[usart_pkg::CMD_IR_BIT]) begin
            // internal reset: back to awaiting the mode word, FIFO emptied
            awaiting_d = 1'b1;
            mode_d     = '0;
            cmd_d      = '0;
            txh_byte_d = '0;
            txh_v_d    = 1'b0;
            tx_busy_d  = 1'b0;
            tx_shift_d = '0;
            tx_edges_d = '0;
            rxd_byte_d = '0;
            rxd_rdy_d  = 1'b0;
            ovr_d      = 1'b0;
            rx_busy_d  = 1'b0;
            rx_edges_d = '0;
            head_d     = '0;
            tail_d     = '0;
            count_d    = '0;
          end else if (!in_i.write_data[usart_pkg::CMD_RXE_BIT]) begin
            rxd_rdy_d = 1'b0;
          end
        end
      end
      usart_pkg::ACT_TX_TICK: begin
        if (cmd_q[usart_pkg::CMD_TXEN_BIT]) begin
          if (tx_busy_q) begin
            if (tx_edges_q > EDGE_W'(1)) begin
              tx_edges_d = tx_edges_q - EDGE_W'(1);
              go         = 1'b0;
            end else begin
              tx_edges_d   = '0;
              tx_busy_d    = 1'b0;
              rsp.tx_valid = 1'b1;
              rsp.tx_byte  = tx_shift_q;
              push_req     = loopback_q;
              push_byte    = tx_shift_q;
            end
          end
          if (go && txh_v_q) begin
            tx_shift_d = txh_byte_q;
            txh_v_d    = 1'b0;
            tx_busy_d  = 1'b1;
            tx_edges_d = usart_pkg::char_ticks(mode_q);
          end
        end
      end
      usart_pkg::ACT_RX_TICK: begin
        if (cmd_q[usart_pkg::CMD_RXE_BIT]) begin
          if (rx_busy_q) begin
            if (rx_edges_q > EDGE_W'(1)) begin
              rx_edges_d = rx_edges_q - EDGE_W'(1);
              go         = 1'b0;
            end else begin
              rx_edges_d = '0;
              rx_busy_d  = 1'b0;
              if (rxd_rdy_q) begin
                ovr_d = 1'b1;
              end
              rxd_byte_d = rx_shift;
              rxd_rdy_d  = 1'b1;
            end
          end
          if (go && (count_q != '0)) begin
            // read the head entry; it lands in the RAM output register
            fifo_re    = 1'b1;
            head_d     = (head_q == LAST_PTR) ? '0 : head_q + PTR_W'(1);
            count_d    = count_q - CNT_W'(1);
            rx_busy_d  = 1'b1;
            rx_edges_d = usart_pkg::char_ticks(mode_q);
          end
        end
      end
      usart_pkg::ACT_LINE_BYTE: begin
        push_req = 1'b1;
      end
      default: begin
      end
    endcase

    if (push_req) begin
      if (count_q >= FULL_CNT) begin
        rsp.queue_dropped = 1'b1;
      end else begin
        fifo_we = 1'b1;
        tail_d  = (tail_q == LAST_PTR) ? '0 : tail_q + PTR_W'(1);
        count_d = count_q + CNT_W'(1);
      end
    end

    rsp.status_bits = usart_pkg::status_word(txh_v_d, tx_busy_d, rxd_rdy_d, ovr_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loopback_q <= 1'b0;
    end else if (cfg_we_i) begin
      loopback_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b1;
      mode_q     <= '0;
      cmd_q      <= '0;
      txh_byte_q <= '0;
      txh_v_q    <= 1'b0;
      tx_busy_q  <= 1'b0;
      tx_shift_q <= '0;
      tx_edges_q <= '0;
      rxd_byte_q <= '0;
      rxd_rdy_q  <= 1'b0;
      ovr_q      <= 1'b0;
      rx_busy_q  <= 1'b0;
      rx_edges_q <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
    end else if (acc) begin
      awaiting_q <= awaiting_d;
      mode_q     <= mode_d;
      cmd_q      <= cmd_d;
      txh_byte_q <= txh_byte_d;
      txh_v_q    <= txh_v_d;
      tx_busy_q  <= tx_busy_d;
      tx_shift_q <= tx_shift_d;
      tx_edges_q <= tx_edges_d;
      rxd_byte_q <= rxd_byte_d;
      rxd_rdy_q  <= rxd_rdy_d;
      ovr_q      <= ovr_d;
      rx_busy_q  <= rx_busy_d;
      rx_edges_q <= rx_edges_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
    end
  end

  usart_fifo_ram #(
    .DEPTH (RX_FIFO_DEPTH),
    .PTR_W (PTR_W)
  ) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (acc & fifo_we),
    .waddr_i (tail_q),
    .wdata_i (push_byte),
    .re_i    (acc & fifo_re),
    .raddr_i (head_q),
    .rdata_o (rx_shift)
  );

  usart_out_skid u_out_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (skid_ready),
    .in_data_i   (rsp),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  assign out_o.read_data     = out_data.read_data;
  assign out_o.status_bits   = out_data.status_bits;
  assign out_o.tx_valid      = out_data.tx_valid;
  assign out_o.tx_byte       = out_data.tx_byte;
  assign out_o.queue_dropped = out_data.queue_dropped;

  // fill level stays within the memory
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("rx fifo count above depth");

  // empty or full FIFO has matching pointers
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((count_q == '0) || (count_q == FULL_CNT)) |-> (head_q == tail_q))
    else $error("rx fifo pointers out of step with count");

  // a busy transmitter always has ticks left
  a_tx_edges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_busy_q |-> (tx_edges_q != '0))
    else $error("tx busy with no ticks left");

  // a busy receiver always has ticks left
  a_rx_edges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_busy_q |-> (rx_edges_q != '0))
    else $error("rx busy with no ticks left");

  // no command is in force before the mode word arrives
  a_mode_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    awaiting_q |-> (cmd_q == '0))
    else $error("command word set while awaiting mode");

endmodule

>>> tb/usart_byte_level_model_core_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usart_byte_level_model_core_monitor
// Watches the request and result channels of the USART core. It keeps its own
// copy of the USART state, works out the result of every accepted request and
// compares each accepted result against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module usart_byte_level_model_core_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  usart_req_if        req,
  usart_rsp_if        rsp,
  output int unsigned fail_count,
  output int unsigned pending_count,
  output int unsigned checked_count,
  output int unsigned chars_sent,
  output int unsigned bytes_dropped
);

  localparam int unsigned EDGE_W = usart_pkg::EDGE_W;

  logic                 loop_en;
  logic                 await_mode;
  logic [7:0]           mode_r;
  logic [7:0]           cmd_r;
  logic [7:0]           hold_byte;
  logic                 hold_full;
  logic                 tx_active;
  logic [7:0]           tx_shift;
  logic [EDGE_W-1:0]    tx_left;
  logic [7:0]           rx_byte;
  logic                 rx_full;
  logic                 overrun;
  logic                 rx_active;
  logic [7:0]           rx_shift;
  logic [EDGE_W-1:0]    rx_left;
  logic [7:0]           line_q[$];
  usart_pkg::rsp_t      results_due[$];

  function automatic void clear_core();
    await_mode = 1'b1;
    mode_r     = '0;
    cmd_r      = '0;
    hold_byte  = '0;
    hold_full  = 1'b0;
    tx_active  = 1'b0;
    tx_shift   = '0;
    tx_left    = '0;
    rx_byte    = '0;
    rx_full    = 1'b0;
    overrun    = 1'b0;
    rx_active  = 1'b0;
    rx_shift   = '0;
    rx_left    = '0;
    line_q.delete();
  endfunction

  // Ticks per character: start, data, optional parity and stop bits, scaled.
  function automatic logic [EDGE_W-1:0] char_len(input logic [7:0] m);
    int unsigned nbits;
    int unsigned mult;
    nbits = 6 + m[3:2] + m[usart_pkg::MODE_PARITY_BIT]
          + ((m[7:6] == usart_pkg::STOP_TWO) ? 2 : 1);
    case (m[1:0])
      usart_pkg::DIV_X16: mult = 16;
      usart_pkg::DIV_X64: mult = 64;
      default: mult = 1;
    endcase
    return EDGE_W'(nbits * mult);
  endfunction

  function automatic logic [7:0] status_byte();
    logic [7:0] s;
    s                        = '0;
    s[usart_pkg::ST_DSR]     = 1'b1;
    s[usart_pkg::ST_TXRDY]   = !hold_full;
    s[usart_pkg::ST_TXEMPTY] = !hold_full && !tx_active;
    s[usart_pkg::ST_RXRDY]   = rx_full;
    s[usart_pkg::ST_OVERRUN] = overrun;
    return s;
  endfunction

  function automatic logic push_line(input logic [7:0] b);
    if (line_q.size() >= usart_pkg::RX_FIFO_DEPTH) return 1'b1;
    line_q.insert(line_q.size(), b);
    return 1'b0;
  endfunction

  // Advance the USART by one request and return the result it yields.
  function automatic usart_pkg::rsp_t run_usart_step(input logic [2:0] act,
                                                     input logic sel,
                                                     input logic [7:0] wd,
                                                     input logic [7:0] lb);
    usart_pkg::rsp_t r;
    logic load;
    r    = '0;
    load = 1'b1;
    case (act)
      usart_pkg::ACT_READ: begin
        if (sel == usart_pkg::REG_CTRL) begin
          r.read_data = status_byte();
        end else begin
          rx_full     = 1'b0;
          r.read_data = rx_byte;
        end
      end
      usart_pkg::ACT_WRITE: begin
        if (sel == usart_pkg::REG_DATA) begin
          hold_byte = wd;
          hold_full = 1'b1;
        end else if (await_mode) begin
          mode_r     = wd;
          await_mode = 1'b0;
        end else begin
          cmd_r = wd;
          if (wd[usart_pkg::CMD_ER_BIT]) overrun = 1'b0;
          if (wd[usart_pkg::CMD_IR_BIT]) begin
            clear_core();
          end else if (!wd[usart_pkg::CMD_RXE_BIT]) begin
            rx_full = 1'b0;
          end
        end
      end
      usart_pkg::ACT_TX_TICK: begin
        if (cmd_r[usart_pkg::CMD_TXEN_BIT]) begin
          if (tx_active) begin
            if (tx_left > 1) begin
              tx_left--;
              load = 1'b0;
            end else begin
              tx_left   = '0;
              tx_active = 1'b0;
              r.tx_valid = 1'b1;
              r.tx_byte  = tx_shift;
              if (loop_en) r.queue_dropped = push_line(tx_shift);
            end
          end
          if (load && hold_full) begin
            tx_shift  = hold_byte;
            hold_full = 1'b0;
            tx_active = 1'b1;
            tx_left   = char_len(mode_r);
          end
        end
      end
      usart_pkg::ACT_RX_TICK: begin
        if (cmd_r[usart_pkg::CMD_RXE_BIT]) begin
          if (rx_active) begin
            if (rx_left > 1) begin
              rx_left--;
              load = 1'b0;
            end else begin
              rx_left   = '0;
              rx_active = 1'b0;
              if (rx_full) overrun = 1'b1;
              rx_byte = rx_shift;
              rx_full = 1'b1;
            end
          end
          if (load && line_q.size() > 0) begin
            rx_shift  = line_q[0];
            line_q.delete(0);
            rx_active = 1'b1;
            rx_left   = char_len(mode_r);
          end
        end
      end
      usart_pkg::ACT_LINE_BYTE: r.queue_dropped = push_line(lb);
      default: ;
    endcase
    r.status_bits = status_byte();
    return r;
  endfunction

  task automatic flag_field(input string field, input logic [7:0] want_v,
                            input logic [7:0] got_v);
    fail_count++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    usart_pkg::rsp_t want;
    usart_pkg::rsp_t got;
    if (!rst_ni) begin
      loop_en = 1'b0;
      clear_core();
      results_due.delete();
      pending_count = 0;
    end else begin
      // Compare before taking the new request, so a stray result cannot pair
      // with a request accepted on the same edge.
      if (rsp.valid && rsp.ready) begin
        got.read_data     = rsp.read_data;
        got.status_bits   = rsp.status_bits;
        got.tx_valid      = rsp.tx_valid;
        got.tx_byte       = rsp.tx_byte;
        got.queue_dropped = rsp.queue_dropped;
        if (results_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got %h %h %b %h %b", $time,
                   got.read_data, got.status_bits, got.tx_valid, got.tx_byte,
                   got.queue_dropped);
        end else begin
          want = results_due[0];
          results_due.delete(0);
          checked_count++;
          if (want.tx_valid) chars_sent++;
          if (want.queue_dropped) bytes_dropped++;
          if (got.read_data !== want.read_data)
            flag_field("read_data", want.read_data, got.read_data);
          if (got.status_bits !== want.status_bits)
            flag_field("status_bits", want.status_bits, got.status_bits);
          if (got.tx_valid !== want.tx_valid)
            flag_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
          if (got.tx_byte !== want.tx_byte)
            flag_field("tx_byte", want.tx_byte, got.tx_byte);
          if (got.queue_dropped !== want.queue_dropped)
            flag_field("queue_dropped", 8'(want.queue_dropped), 8'(got.queue_dropped));
        end
      end
      if (req.valid && req.ready)
        results_due.insert(results_due.size(),
                           run_usart_step(req.action, req.reg_select,
                                          req.write_data, req.line_byte));
      if (cfg_we_i) loop_en = cfg_wdata_i;
      pending_count = results_due.size();
    end
  end

endmodule

>>> tb/usart_byte_level_model_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usart_byte_level_model_core_tb
// Drives the USART core with bus reads and writes, baud ticks and line bytes:
// a directed opening, then phases with loopback on and off, FIFO floods,
// slow divisors and random traffic under varying idle and stall patterns.
// The monitor beside the core checks every result; this module only makes
// stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module usart_byte_level_model_core_tb;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned HOLD_OFF_CYCLES  = 100;
  localparam int unsigned RANDOM_PER_PHASE = 297;
  localparam int unsigned PHASE_COUNT      = 4;
  localparam int unsigned FLOOD_LEN        = usart_pkg::RX_FIFO_DEPTH + 2;
  // div64, 5 data bits, one stop: 7 * 64 = 448 ticks, plus margin
  localparam int unsigned SLOW_TX_TICKS    = 450;
  // div16, 8 data bits, parity, two stop: 12 * 16 = 192 ticks, plus margin
  localparam int unsigned SLOW_RX_TICKS    = 194;
  localparam logic [7:0]  MODE_SLOW_TX     = 8'h03;
  localparam logic [7:0]  MODE_SLOW_RX     = 8'hDE;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  usart_req_if req_if ();
  usart_rsp_if rsp_if ();

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned chars_sent;
  int unsigned bytes_dropped;
  int unsigned cycle_count;
  int unsigned sent_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_off_go;
  // Next control write is taken as the mode word (after reset or IR).
  bit          mode_due;

  usart_byte_level_model_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_if),
    .out_o       (rsp_if)
  );

  usart_byte_level_model_core_monitor u_mon (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req           (req_if),
    .rsp           (rsp_if),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count),
    .chars_sent    (chars_sent),
    .bytes_dropped (bytes_dropped)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: stall at the phase's rate. On request, hold off for a long
  // stretch so the core's output slots fill and it stops taking requests.
  initial begin : result_side
    int unsigned held;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        rsp_if.ready <= 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) @(negedge clk_i);
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one request from a falling edge, hold it until accepted, then
  // maybe drop valid for a short random gap. Returns on a falling edge.
  task automatic send_req(input logic [2:0] act, input logic sel,
                          input logic [7:0] wd, input logic [7:0] lb);
    int unsigned gap;
    req_if.valid      <= 1'b1;
    req_if.action     <= act;
    req_if.reg_select <= sel;
    req_if.write_data <= wd;
    req_if.line_byte  <= lb;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent_count++;
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      gap = $urandom_range(3, 1);
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Control write; track whether it lands as mode or as command.
  task automatic ctrl_write(input logic [7:0] v);
    send_req(usart_pkg::ACT_WRITE, usart_pkg::REG_CTRL, v, 8'($urandom));
    if (mode_due) mode_due = 1'b0;
    else if (v[usart_pkg::CMD_IR_BIT]) mode_due = 1'b1;
  endtask

  // Mostly fast divisors; x16 and x64 only now and then.
  function automatic logic [7:0] pick_mode();
    logic [7:0] m;
    m = 8'($urandom);
    if ($urandom_range(99) < 96) m[1] = 1'b0;
    return m;
  endfunction

  // Keep transmitter and receiver mostly on; internal reset is rare.
  function automatic logic [7:0] pick_command();
    logic [7:0] c;
    c = 8'($urandom);
    c[usart_pkg::CMD_TXEN_BIT] = ($urandom_range(9) != 0);
    c[usart_pkg::CMD_RXE_BIT]  = ($urandom_range(9) != 0);
    c[usart_pkg::CMD_IR_BIT]   = ($urandom_range(24) == 0);
    return c;
  endfunction

  // Internal reset (unless mode is already due), then mode and an enabling
  // command, so the link is live again.
  task automatic restart_link(input logic [7:0] mode);
    logic [7:0] c;
    if (!mode_due) begin
      c = pick_command();
      c[usart_pkg::CMD_IR_BIT] = 1'b1;
      ctrl_write(c);
    end
    ctrl_write(mode);
    c = pick_command();
    c[usart_pkg::CMD_TXEN_BIT] = 1'b1;
    c[usart_pkg::CMD_RXE_BIT]  = 1'b1;
    c[usart_pkg::CMD_IR_BIT]   = 1'b0;
    ctrl_write(c);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [7:0]  a;
    logic [7:0]  b;
    pick = $urandom_range(99);
    a    = 8'($urandom);
    b    = 8'($urandom);
    if (pick < 15) begin
      send_req(usart_pkg::ACT_READ, 1'($urandom), a, b);
    end else if (pick < 23) begin
      send_req(usart_pkg::ACT_WRITE, usart_pkg::REG_DATA, a, b);
    end else if (pick < 26) begin
      // After an internal reset, bring the link straight back up.
      ctrl_write(mode_due ? pick_mode() : pick_command());
      while (mode_due) begin
        ctrl_write(pick_mode());
        ctrl_write(pick_command());
      end
    end else if (pick < 56) begin
      send_req(usart_pkg::ACT_TX_TICK, 1'($urandom), a, b);
    end else if (pick < 86) begin
      send_req(usart_pkg::ACT_RX_TICK, 1'($urandom), a, b);
    end else if (pick < 98) begin
      send_req(usart_pkg::ACT_LINE_BYTE, 1'($urandom), a, b);
    end else begin
      // unused action codes: status only, nothing changes
      send_req(3'($urandom_range(7, 5)), 1'($urandom), a, b);
    end
  endtask

  // Drop valid and wait until every outstanding result has come back.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Only called while the core is idle.
  task automatic set_loopback(input logic en);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned ph;
    int unsigned i;
    req_if.valid      = 1'b0;
    req_if.action     = usart_pkg::ACT_READ;
    req_if.reg_select = usart_pkg::REG_DATA;
    req_if.write_data = 8'h00;
    req_if.line_byte  = 8'h00;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = 1'b0;
    rst_ni            = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_off_go       = 1'b0;
    mode_due          = 1'b1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    set_loopback(1'b0);

    // Directed opening: reads before any mode, unused codes, extreme bytes,
    // holding overwrite, command without RxE, disabled ticks, internal reset.
    send_req(usart_pkg::ACT_READ, usart_pkg::REG_CTRL, 8'h00, 8'h00);
    send_req(usart_pkg::ACT_READ, usart_pkg::REG_DATA, 8'h00, 8'h00);
    send_req(3'd5, usart_pkg::REG_DATA, 8'h00, 8'h00);
    send_req(3'd7, usart_pkg::REG_CTRL, 8'hFF, 8'hFF);
    send_req(usart_pkg::ACT_LINE_BYTE, usart_pkg::REG_DATA, 8'h00, 8'hFF);
    send_req(usart_pkg::ACT_LINE_BYTE, usart_pkg::REG_CTRL, 8'hFF, 8'h00);
    ctrl_write(8'hFD);  // x1, 8 data bits, parity, two stop bits
    ctrl_write(8'h15);  // TxEN, RxE, error reset
    send_req(usart_pkg::ACT_WRITE, usart_pkg::REG_DATA, 8'hA5, 8'h00);
    send_req(usart_pkg::ACT_WRITE, usart_pkg::REG_DATA, 8'h5A, 8'h00);
    send_req(usart_pkg::ACT_TX_TICK, usart_pkg::REG_DATA, 8'h00, 8'h00);
    send_req(usart_pkg::ACT_READ, usart_pkg::REG_CTRL, 8'h00, 8'h00);
    send_req(usart_pkg::ACT_RX_TICK, usart_pkg::REG_DATA, 8'h00, 8'h00);
    ctrl_write(8'h11);  // receiver off: drop RxRDY
    ctrl_write(8'h00);  // both sides off
    send_req(usart_pkg::ACT_TX_TICK, usart_pkg::REG_CTRL, 8'h00, 8'h00);
    send_req(usart_pkg::ACT_RX_TICK, usart_pkg::REG_CTRL, 8'h00, 8'h00);
    ctrl_write(8'h40);  // internal reset
    ctrl_write(8'h00);  // synchronous mode, shortest character
    ctrl_write(8'hBF);  // every command bit but internal reset
    send_req(3'd6, usart_pkg::REG_DATA, 8'h00, 8'h00);
    send_req(usart_pkg::ACT_READ, usart_pkg::REG_DATA, 8'h00, 8'h00);

    // Random phases: each starts idle with a new loopback setting, restarts
    // the link, floods the receive FIFO past full, then runs random traffic.
    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      drain_results();
      set_loopback(ph[0]);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      restart_link(pick_mode());
      // Hold off results while requests keep coming, so the core backs up.
      if (send_idle_pct == 0) hold_off_go = 1'b1;
      for (i = 0; i < FLOOD_LEN; i++)
        send_req(usart_pkg::ACT_LINE_BYTE, 1'($urandom), 8'($urandom), 8'($urandom));
      for (i = 0; i < RANDOM_PER_PHASE; i++) send_random_item();
    end

    // Slow divisors: one full x64 transmit in loopback, one full x16 receive.
    drain_results();
    set_loopback(1'b1);
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    restart_link(MODE_SLOW_TX);
    send_req(usart_pkg::ACT_WRITE, usart_pkg::REG_DATA, 8'hC3, 8'h00);
    for (i = 0; i < SLOW_TX_TICKS; i++)
      send_req(usart_pkg::ACT_TX_TICK, usart_pkg::REG_DATA, 8'h00, 8'h00);
    restart_link(MODE_SLOW_RX);
    send_req(usart_pkg::ACT_LINE_BYTE, usart_pkg::REG_DATA, 8'h00, 8'h96);
    for (i = 0; i < SLOW_RX_TICKS; i++)
      send_req(usart_pkg::ACT_RX_TICK, usart_pkg::REG_DATA, 8'h00, 8'h00);
    send_req(usart_pkg::ACT_READ, usart_pkg::REG_CTRL, 8'h00, 8'h00);
    send_req(usart_pkg::ACT_READ, usart_pkg::REG_DATA, 8'h00, 8'h00);

    drain_results();
    $display("Covered %0d requests: directed, FIFO floods, random phases, slow divisors",
             sent_count);
    $display("Checked %0d results; %0d characters sent, %0d bytes dropped on full FIFO",
             checked_count, chars_sent, bytes_dropped);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
